>>> rtl/sssd_pkg.sv
`default_nettype none

package sssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = $clog2(DIGIT_COUNT);
    localparam int DIGIT_W     = 4;
    localparam int SEG_W       = 8;
    localparam int VALUE_W     = 14;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 8;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

    // Reciprocal constants for divide by 1000, 100 and 10 over 0..9999
    localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23
    localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
    localparam logic [12:0] RECIP_10   = 13'd6554;   // >> 16

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ROUNDS = 8'd1;

    localparam logic [CFG_W-1:0] DWELL_RESET  = 16'd2;
    localparam logic [CFG_W-1:0] ROUNDS_RESET = 16'd100;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h81;
            4'd1:    pat = 8'hf3;
            4'd2:    pat = 8'h49;
            4'd3:    pat = 8'h61;
            4'd4:    pat = 8'h33;
            4'd5:    pat = 8'h25;
            4'd6:    pat = 8'h05;
            4'd7:    pat = 8'hf1;
            4'd8:    pat = 8'h01;
            4'd9:    pat = 8'h21;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

>>> rtl/seven_segment_scan_driver.sv
// Four-digit multiplexed seven-segment scan driver.
//
// Input channel (s_*): one transaction per item. s_tuser selects the kind:
// load (0) takes s_tdata as the value to show, saturated to 9999; tick (1)
// is the one-millisecond time base that paces the digit scan.
// Result channel (m_*): exactly one transaction per input item, carrying the
// digit enables, the segment pattern and the scanning flag after that item.
// Configuration channel (cfg_*): index 0 writes dwell_ticks, index 1 writes
// scan_rounds; other indexes are dropped. Write only while the block is idle.
//
// From input to result, the first register holds the item with its
// reciprocal-multiply quotients; the second stage finishes the decimal
// split, advances the scan state and fills the result register.
// Throughput is one item per cycle while the receiver takes results.
// When m_tready is low the result register holds, the input register fills
// behind it and then s_tready drops. Reset clears the pipeline, turns the
// display dark with a zero segment pattern and restores dwell_ticks = 2 and
// scan_rounds = 100.
`default_nettype none

module seven_segment_scan_driver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] show_value, [15:14] zero
    input  wire logic        s_tuser,   // [0] func
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [3:0] digit_enable, [11:4] segments,
                                        // [12] scanning, [15:13] zero
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int PW = sssd_pkg::POS_W;
    localparam int DW = sssd_pkg::DIGIT_W;
    localparam int SW = sssd_pkg::SEG_W;
    localparam int VW = sssd_pkg::VALUE_W;
    localparam int CW = sssd_pkg::CFG_W;
    localparam int DC = sssd_pkg::DIGIT_COUNT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] dwell_ticks_reg;
    logic [CW-1:0] scan_rounds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg <= sssd_pkg::DWELL_RESET;
            scan_rounds_reg <= sssd_pkg::ROUNDS_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == sssd_pkg::REG_DWELL_TICKS) begin
                dwell_ticks_reg <= cfg_data;
            end else if (cfg_index == sssd_pkg::REG_SCAN_ROUNDS) begin
                scan_rounds_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register: saturate and take the three reciprocal products
    // ------------------------------------------------------------------
    logic          in_valid_reg;
    logic          in_func_reg;
    logic [VW-1:0] in_val_reg;
    logic [3:0]    in_thou_reg;
    logic [6:0]    in_q100_reg;
    logic [9:0]    in_q10_reg;

    logic          adv;        // stage 2 consumes the input register
    logic          s_accept;
    logic [VW-1:0] v_sat;
    logic [26:0]   prod_thou;
    logic [25:0]   prod_hund;
    logic [25:0]   prod_ten;

    assign adv      = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        v_sat     = (s_tdata[VW-1:0] > sssd_pkg::VALUE_MAX) ? sssd_pkg::VALUE_MAX
                                                            : s_tdata[VW-1:0];
        prod_thou = 27'(v_sat) * 27'(sssd_pkg::RECIP_1000);
        prod_hund = 26'(v_sat) * 26'(sssd_pkg::RECIP_100);
        prod_ten  = 26'(v_sat) * 26'(sssd_pkg::RECIP_10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_func_reg <= s_tuser;
            in_val_reg  <= v_sat;
            in_thou_reg <= prod_thou[26:23];
            in_q100_reg <= prod_hund[25:19];
            in_q10_reg  <= prod_ten[25:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: finish the decimal split and step the scan
    // ------------------------------------------------------------------
    logic [DW-1:0] digit_reg [DC];
    logic [PW-1:0] first_pos_reg;
    logic [PW-1:0] cur_pos_reg;
    logic [CW-1:0] dwell_cnt_reg;
    logic [CW-1:0] round_cnt_reg;
    logic          active_reg;
    logic [SW-1:0] seg_reg;

    logic [DW-1:0] digit_next [DC];
    logic [PW-1:0] first_pos_next;
    logic [PW-1:0] cur_pos_next;
    logic [CW-1:0] dwell_cnt_next;
    logic [CW-1:0] round_cnt_next;
    logic          active_next;
    logic [SW-1:0] seg_next;

    logic [6:0]    hund_full;
    logic [9:0]    ten_full;
    logic [VW-1:0] unit_full;
    logic [CW-1:0] limit;
    logic [CW-1:0] dwell_inc;
    logic [CW-1:0] round_dec;
    logic          load_item;

    assign load_item = (in_func_reg == sssd_pkg::FUNC_LOAD);

    always_comb begin
        // remainders from the registered quotients; times ten is shift-add
        hund_full = in_q100_reg - 7'(in_thou_reg) * 7'd10;
        ten_full  = in_q10_reg - 10'(in_q100_reg) * 10'd10;
        unit_full = in_val_reg - VW'(in_q10_reg) * VW'(10);

        limit     = (dwell_ticks_reg == '0) ? CW'(1) : dwell_ticks_reg;
        dwell_inc = dwell_cnt_reg + CW'(1);
        round_dec = round_cnt_reg - CW'(1);

        for (int k = 0; k < DC; k++) begin
            digit_next[k] = digit_reg[k];
        end
        first_pos_next = first_pos_reg;
        cur_pos_next   = cur_pos_reg;
        dwell_cnt_next = dwell_cnt_reg;
        round_cnt_next = round_cnt_reg;
        active_next    = active_reg;
        seg_next       = seg_reg;

        if (load_item) begin
            digit_next[3] = in_thou_reg;
            digit_next[2] = hund_full[DW-1:0];
            digit_next[1] = ten_full[DW-1:0];
            digit_next[0] = unit_full[DW-1:0];
            // blank leading zeros: start at the highest nonzero quotient
            priority if (in_thou_reg != '0) begin
                first_pos_next = PW'(3);
            end else if (in_q100_reg != '0) begin
                first_pos_next = PW'(2);
            end else if (in_q10_reg != '0) begin
                first_pos_next = PW'(1);
            end else begin
                first_pos_next = PW'(0);
            end
            cur_pos_next   = first_pos_next;
            dwell_cnt_next = '0;
            round_cnt_next = scan_rounds_reg;
            active_next    = (scan_rounds_reg != '0);
            seg_next       = sssd_pkg::seg_pattern(digit_next[cur_pos_next]);
        end else if (active_reg) begin
            dwell_cnt_next = dwell_inc;
            if (dwell_inc >= limit) begin
                dwell_cnt_next = '0;
                if (cur_pos_reg == '0) begin
                    // end of one round
                    round_cnt_next = round_dec;
                    if (round_dec == '0) begin
                        active_next = 1'b0;
                    end else begin
                        cur_pos_next = first_pos_reg;
                    end
                end else begin
                    cur_pos_next = cur_pos_reg - PW'(1);
                end
                // dark keeps the last pattern on the segment lines
                if (active_next) begin
                    seg_next = sssd_pkg::seg_pattern(digit_reg[cur_pos_next]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DC; k++) begin
                digit_reg[k] <= '0;
            end
            first_pos_reg <= '0;
            cur_pos_reg   <= '0;
            dwell_cnt_reg <= '0;
            round_cnt_reg <= '0;
            active_reg    <= 1'b0;
            seg_reg       <= '0;
        end else if (adv) begin
            for (int k = 0; k < DC; k++) begin
                digit_reg[k] <= digit_next[k];
            end
            first_pos_reg <= first_pos_next;
            cur_pos_reg   <= cur_pos_next;
            dwell_cnt_reg <= dwell_cnt_next;
            round_cnt_reg <= round_cnt_next;
            active_reg    <= active_next;
            seg_reg       <= seg_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;
    logic [DC-1:0] enable_next;

    always_comb begin
        enable_next = '0;
        if (active_next) begin
            enable_next[cur_pos_next] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {3'b000, active_next, seg_next, enable_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // at most one digit is driven at a time
    a_enable_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[3:0]))
        else $error("more than one digit enable set");

    // the scanning flag and the digit enables agree
    a_scan_matches_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12] == (m_tdata[3:0] != 4'd0)))
        else $error("scanning flag disagrees with digit enables");

    // an active scan always has rounds left
    a_active_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (round_cnt_reg != '0))
        else $error("scan active with no rounds left");

    // a load with rounds configured starts the scan
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && load_item && (scan_rounds_reg != '0)) |=> active_reg)
        else $error("load did not start the scan");
`endif

endmodule

`default_nettype wire
